FILE: hdl/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// Holds the heap geometry, entry layout, opcodes, status codes and sequencer states.
// No dependencies.
package bmhq_pkg;

    localparam int CAPACITY    = 256;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CHILD_W     = ADDR_W + 2;
    localparam int KEY_W       = 32;
    localparam int PAY_W       = 16;
    localparam int ENTRY_W     = KEY_W + PAY_W;
    localparam int COUNT_OUT_W = 9;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } t_entry;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_APPEND  = 2'd2,
        OP_BUILD   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_EX_ROOT,
        ST_EX_LAST,
        ST_SD_LEFT,
        ST_SD_RIGHT,
        ST_SD_CMP,
        ST_BLD_NEXT,
        ST_BLD_LOAD,
        ST_FIN
    } t_state;

endpackage

FILE: hdl/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used as heap storage; no dependencies.
module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue: sequencer, shared key comparator and heap RAM.
// Depends on bmhq_pkg and bmhq_ram.
//
// Usage: one operation per input transfer (i_valid/o_ready) carrying an opcode, key
// and payload; each operation returns exactly one result transfer (o_valid/i_ready)
// with status, extracted key/payload (zero unless an extract succeeds) and the
// entry count after the operation.
// Append, overflow and underflow go straight to the result. Insert climbs while its key
// is strictly smaller than the parent's; extract moves the last entry to the root and
// sifts it down; build sifts down each parent from the last one to the root.
// Every step of a sift is a RAM read with registered data and a compare in the single
// shared key comparator; a step down reads and compares both children in turn.
// The block takes no new item while an operation runs; it does accept the next item
// while a finished result still waits in the output register.
// A stalled receiver holds the result register; a finished operation then waits until
// the register frees up.
// Reset empties the heap at once (count to zero); RAM contents are left as they are,
// since only entries below the count are ever used.
module binary_min_heap_queue_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_opcode,
    input  logic [bmhq_pkg::KEY_W-1:0]           i_item_key,
    input  logic [bmhq_pkg::PAY_W-1:0]           i_item_payload,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_status,
    output logic [bmhq_pkg::KEY_W-1:0]           o_out_key,
    output logic [bmhq_pkg::PAY_W-1:0]           o_out_payload,
    output logic [bmhq_pkg::COUNT_OUT_W-1:0]     o_entry_count
);

    localparam int ADDR_W  = bmhq_pkg::ADDR_W;
    localparam int CNT_W   = bmhq_pkg::CNT_W;
    localparam int CHILD_W = bmhq_pkg::CHILD_W;
    localparam int KEY_W   = bmhq_pkg::KEY_W;

    bmhq_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_bi, n_bi;
    logic [ADDR_W-1:0] r_best_idx, n_best_idx;
    bmhq_pkg::t_entry  r_x, n_x;
    bmhq_pkg::t_entry  r_best, n_best;
    logic              r_best_sel, n_best_sel;
    logic              r_r_ok, n_r_ok;
    logic              r_build, n_build;
    bmhq_pkg::t_status r_status, n_status;
    bmhq_pkg::t_entry  r_res, n_res;
    logic              r_out_valid, n_out_valid;
    bmhq_pkg::t_status r_out_status, n_out_status;
    bmhq_pkg::t_entry  r_out_res, n_out_res;
    logic [bmhq_pkg::COUNT_OUT_W-1:0] r_out_count, n_out_count;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    bmhq_pkg::t_entry        ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [bmhq_pkg::ENTRY_W-1:0] ram_rdata_raw;
    bmhq_pkg::t_entry        ram_rdata;

    logic                    in_xfer;
    logic                    heap_full;
    logic                    heap_empty;
    logic                    fin_load;
    logic [CHILD_W-1:0]      w_lchild;
    logic [CHILD_W-1:0]      w_rchild;
    logic                    w_l_ok;
    logic [ADDR_W-1:0]       w_parent;
    logic [KEY_W-1:0]        cmp_a, cmp_b;
    logic                    cmp_lt;
    logic                    sd_take_right;
    bmhq_pkg::t_state        sd_exit;

    bmhq_ram #(
        .WIDTH (bmhq_pkg::ENTRY_W),
        .DEPTH (bmhq_pkg::CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata  = bmhq_pkg::t_entry'(ram_rdata_raw);
    assign o_ready    = (r_state == bmhq_pkg::ST_IDLE);
    assign in_xfer    = i_valid && o_ready;
    assign heap_full  = (r_count >= CNT_W'(bmhq_pkg::CAPACITY));
    assign heap_empty = (r_count == '0);
    assign fin_load   = (r_state == bmhq_pkg::ST_FIN) && (!r_out_valid || i_ready);

    // Child and parent indexes of the current hole
    assign w_lchild = {1'b0, r_idx, 1'b1};
    assign w_rchild = w_lchild + CHILD_W'(1);
    assign w_l_ok   = (w_lchild < CHILD_W'(r_count));
    assign w_parent = (r_idx - ADDR_W'(1)) >> 1;

    // Shared key comparator: cmp_a < cmp_b
    always_comb begin
        case (r_state)
            bmhq_pkg::ST_INS_CMP: begin
                cmp_a = r_x.key;
                cmp_b = ram_rdata.key;
            end
            bmhq_pkg::ST_SD_RIGHT: begin
                cmp_a = ram_rdata.key;
                cmp_b = r_x.key;
            end
            bmhq_pkg::ST_SD_CMP: begin
                cmp_a = ram_rdata.key;
                cmp_b = r_best.key;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt        = (cmp_a < cmp_b);
    assign sd_take_right = r_r_ok && cmp_lt;
    assign sd_exit       = r_build ? bmhq_pkg::ST_BLD_NEXT : bmhq_pkg::ST_FIN;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmhq_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (bmhq_pkg::t_opcode'(i_opcode))
                        bmhq_pkg::OP_INSERT:
                            n_state = heap_full ? bmhq_pkg::ST_FIN : bmhq_pkg::ST_INS_RD;
                        bmhq_pkg::OP_EXTRACT:
                            n_state = heap_empty ? bmhq_pkg::ST_FIN : bmhq_pkg::ST_EX_ROOT;
                        bmhq_pkg::OP_BUILD:
                            n_state = bmhq_pkg::ST_BLD_NEXT;
                        default:
                            n_state = bmhq_pkg::ST_FIN;
                    endcase
                end
            end
            bmhq_pkg::ST_INS_RD:
                n_state = (r_idx == '0) ? bmhq_pkg::ST_FIN : bmhq_pkg::ST_INS_CMP;
            bmhq_pkg::ST_INS_CMP:
                n_state = cmp_lt ? bmhq_pkg::ST_INS_RD : bmhq_pkg::ST_FIN;
            bmhq_pkg::ST_EX_ROOT:
                n_state = bmhq_pkg::ST_EX_LAST;
            bmhq_pkg::ST_EX_LAST:
                n_state = bmhq_pkg::ST_SD_LEFT;
            bmhq_pkg::ST_SD_LEFT:
                n_state = w_l_ok ? bmhq_pkg::ST_SD_RIGHT : sd_exit;
            bmhq_pkg::ST_SD_RIGHT:
                n_state = bmhq_pkg::ST_SD_CMP;
            bmhq_pkg::ST_SD_CMP:
                n_state = (sd_take_right || r_best_sel) ? bmhq_pkg::ST_SD_LEFT : sd_exit;
            bmhq_pkg::ST_BLD_NEXT:
                n_state = (r_bi == '0) ? bmhq_pkg::ST_FIN : bmhq_pkg::ST_BLD_LOAD;
            bmhq_pkg::ST_BLD_LOAD:
                n_state = bmhq_pkg::ST_SD_LEFT;
            bmhq_pkg::ST_FIN:
                n_state = fin_load ? bmhq_pkg::ST_IDLE : bmhq_pkg::ST_FIN;
            default:
                n_state = bmhq_pkg::ST_IDLE;
        endcase
    end

    // RAM control and datapath registers
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_bi         = r_bi;
        n_best_idx   = r_best_idx;
        n_x          = r_x;
        n_best       = r_best;
        n_best_sel   = r_best_sel;
        n_r_ok       = r_r_ok;
        n_build      = r_build;
        n_status     = r_status;
        n_res        = r_res;
        n_out_status = r_out_status;
        n_out_res    = r_out_res;
        n_out_count  = r_out_count;
        n_out_valid  = i_ready ? 1'b0 : r_out_valid;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = r_x;
        ram_raddr    = '0;

        case (r_state)
            bmhq_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_status = bmhq_pkg::STAT_OK;
                    n_res    = '0;
                    n_build  = 1'b0;
                    n_x      = '{key: i_item_key, pay: i_item_payload};
                    case (bmhq_pkg::t_opcode'(i_opcode))
                        bmhq_pkg::OP_INSERT: begin
                            if (heap_full) begin
                                n_status = bmhq_pkg::STAT_FULL;
                            end else begin
                                n_idx   = r_count[ADDR_W-1:0];
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        bmhq_pkg::OP_APPEND: begin
                            if (heap_full) begin
                                n_status = bmhq_pkg::STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[ADDR_W-1:0];
                                ram_wdata = '{key: i_item_key, pay: i_item_payload};
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        bmhq_pkg::OP_EXTRACT: begin
                            if (heap_empty) begin
                                n_status = bmhq_pkg::STAT_EMPTY;
                            end
                            ram_raddr = '0;
                        end
                        default: begin
                            n_build = 1'b1;
                            n_bi    = ADDR_W'(r_count >> 1);
                        end
                    endcase
                end
            end
            bmhq_pkg::ST_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we = 1'b1;
                end
                ram_raddr = w_parent;
            end
            bmhq_pkg::ST_INS_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    // move parent down into the hole and climb
                    ram_wdata = ram_rdata;
                    n_idx     = w_parent;
                end
            end
            bmhq_pkg::ST_EX_ROOT: begin
                n_res     = ram_rdata;
                ram_raddr = ADDR_W'(r_count - CNT_W'(1));
                n_count   = r_count - CNT_W'(1);
            end
            bmhq_pkg::ST_EX_LAST: begin
                n_x   = ram_rdata;
                n_idx = '0;
            end
            bmhq_pkg::ST_SD_LEFT: begin
                if (w_l_ok) begin
                    ram_raddr = w_lchild[ADDR_W-1:0];
                end else begin
                    ram_we = 1'b1;
                end
            end
            bmhq_pkg::ST_SD_RIGHT: begin
                ram_raddr = w_rchild[ADDR_W-1:0];
                n_r_ok    = (w_rchild < CHILD_W'(r_count));
                if (cmp_lt) begin
                    n_best     = ram_rdata;
                    n_best_sel = 1'b1;
                    n_best_idx = w_lchild[ADDR_W-1:0];
                end else begin
                    n_best     = r_x;
                    n_best_sel = 1'b0;
                end
            end
            bmhq_pkg::ST_SD_CMP: begin
                ram_we = 1'b1;
                if (sd_take_right) begin
                    ram_wdata = ram_rdata;
                    n_idx     = w_rchild[ADDR_W-1:0];
                end else if (r_best_sel) begin
                    ram_wdata = r_best;
                    n_idx     = r_best_idx;
                end
            end
            bmhq_pkg::ST_BLD_NEXT: begin
                if (r_bi != '0) begin
                    n_bi      = r_bi - ADDR_W'(1);
                    ram_raddr = r_bi - ADDR_W'(1);
                end
            end
            bmhq_pkg::ST_BLD_LOAD: begin
                n_x   = ram_rdata;
                n_idx = r_bi;
            end
            bmhq_pkg::ST_FIN: begin
                if (fin_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_res    = r_res;
                    n_out_count  = bmhq_pkg::COUNT_OUT_W'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmhq_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_build     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_build     <= n_build;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_bi         <= n_bi;
        r_best_idx   <= n_best_idx;
        r_x          <= n_x;
        r_best       <= n_best;
        r_best_sel   <= n_best_sel;
        r_r_ok       <= n_r_ok;
        r_status     <= n_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_res    <= n_out_res;
        r_out_count  <= n_out_count;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_key     = r_out_res.key;
    assign o_out_payload = r_out_res.pay;
    assign o_entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(bmhq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_opcode == bmhq_pkg::OP_EXTRACT && heap_empty)
        |=> (r_status == bmhq_pkg::STAT_EMPTY && r_state == bmhq_pkg::ST_FIN))
        else $error("extract on empty heap not flagged");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmhq_pkg::ST_IDLE && !in_xfer) |=> $stable(r_count))
        else $error("entry count changed with no operation");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_load |=> (o_valid && o_status == $past(r_status)))
        else $error("finished result not presented");

endmodule

FILE: tb/binary_min_heap_queue_unit_test.sv
// Self-checking testbench for binary_min_heap_queue_unit: random valid/ready traffic,
// a heap predictor in the scoreboard and a field-by-field compare of each result.
// Depends on bmhq_pkg and the RTL of binary_min_heap_queue_unit.
module binary_min_heap_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bmhq_pkg::t_status status;
        logic [31:0]       key;
        logic [15:0]       tag;
        logic [8:0]        count;
        int unsigned       seq;
    } t_heap_result;

    class heap_scoreboard;
        logic [bmhq_pkg::KEY_W-1:0] heap_keys [bmhq_pkg::CAPACITY];
        logic [bmhq_pkg::PAY_W-1:0] heap_tags [bmhq_pkg::CAPACITY];
        int unsigned        held_count;
        int unsigned        accepted;
        int unsigned        errors;
        t_heap_result       awaited_results [$];

        function new();
            held_count = 0;
            accepted   = 0;
            errors     = 0;
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Push the entry at idx down until neither child holds a strictly smaller key.
        function void sink_entry(int unsigned idx);
            int unsigned                best;
            int unsigned                lc;
            int unsigned                rc;
            logic [bmhq_pkg::KEY_W-1:0] k;
            logic [bmhq_pkg::PAY_W-1:0] t;
            while (idx < held_count) begin
                best = idx;
                lc   = 2 * idx + 1;
                rc   = 2 * idx + 2;
                if (lc < held_count && heap_keys[lc] < heap_keys[best])
                    best = lc;
                if (rc < held_count && heap_keys[rc] < heap_keys[best])
                    best = rc;
                if (best == idx)
                    break;
                k               = heap_keys[best];
                t               = heap_tags[best];
                heap_keys[best] = heap_keys[idx];
                heap_tags[best] = heap_tags[idx];
                heap_keys[idx]  = k;
                heap_tags[idx]  = t;
                idx = best;
            end
        endfunction

        function void note_request(bmhq_pkg::t_opcode op, logic [bmhq_pkg::KEY_W-1:0] key,
                                   logic [bmhq_pkg::PAY_W-1:0] tag);
            t_heap_result res;
            int unsigned  slot;
            int unsigned  parent;
            res.status = bmhq_pkg::STAT_OK;
            res.key    = '0;
            res.tag    = '0;
            res.seq    = accepted;
            case (op)
                bmhq_pkg::OP_INSERT, bmhq_pkg::OP_APPEND: begin
                    if (held_count >= bmhq_pkg::CAPACITY) begin
                        res.status = bmhq_pkg::STAT_FULL;
                    end else if (op == bmhq_pkg::OP_APPEND) begin
                        heap_keys[held_count] = key;
                        heap_tags[held_count] = tag;
                        held_count++;
                    end else begin
                        slot = held_count;
                        held_count++;
                        // climb while strictly smaller; an equal parent stops it
                        while (slot > 0) begin
                            parent = (slot - 1) / 2;
                            if (!(key < heap_keys[parent]))
                                break;
                            heap_keys[slot] = heap_keys[parent];
                            heap_tags[slot] = heap_tags[parent];
                            slot = parent;
                        end
                        heap_keys[slot] = key;
                        heap_tags[slot] = tag;
                    end
                end
                bmhq_pkg::OP_EXTRACT: begin
                    if (held_count == 0) begin
                        res.status = bmhq_pkg::STAT_EMPTY;
                    end else begin
                        res.key = heap_keys[0];
                        res.tag = heap_tags[0];
                        held_count--;
                        heap_keys[0] = heap_keys[held_count];
                        heap_tags[0] = heap_tags[held_count];
                        sink_entry(0);
                    end
                end
                bmhq_pkg::OP_BUILD: begin
                    if (held_count >= 2)
                        for (int i = held_count / 2; i > 0; i--)
                            sink_entry(i - 1);
                end
                default: begin
                end
            endcase
            res.count = held_count[8:0];
            awaited_results.insert(awaited_results.size(), res);
            accepted++;
        endfunction

        task check_result(logic [1:0] status, logic [bmhq_pkg::KEY_W-1:0] key,
                          logic [bmhq_pkg::PAY_W-1:0] tag,
                          logic [bmhq_pkg::COUNT_OUT_W-1:0] count);
            t_heap_result want;
            if (awaited_results.size() == 0) begin
                flag_mismatch("result transfer with no request outstanding");
            end else begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                    flag_mismatch($sformatf("item %0d status got %0d want %0d",
                                            want.seq, status, want.status));
                if (key !== want.key)
                    flag_mismatch($sformatf("item %0d key got %h want %h",
                                            want.seq, key, want.key));
                if (tag !== want.tag)
                    flag_mismatch($sformatf("item %0d payload got %h want %h",
                                            want.seq, tag, want.tag));
                if (count !== want.count)
                    flag_mismatch($sformatf("item %0d count got %0d want %0d",
                                            want.seq, count, want.count));
            end
        endtask
    endclass

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             i_valid        = 1'b0;
    logic [1:0]                       i_opcode       = '0;
    logic [bmhq_pkg::KEY_W-1:0]       i_item_key     = '0;
    logic [bmhq_pkg::PAY_W-1:0]       i_item_payload = '0;
    logic                             i_ready        = 1'b0;
    logic                             o_ready;
    logic                             o_valid;
    logic [1:0]                       o_status;
    logic [bmhq_pkg::KEY_W-1:0]       o_out_key;
    logic [bmhq_pkg::PAY_W-1:0]       o_out_payload;
    logic [bmhq_pkg::COUNT_OUT_W-1:0] o_entry_count;

    int unsigned    send_idle_pct = 28;
    int unsigned    recv_idle_pct = 59;
    heap_scoreboard board = new();

    binary_min_heap_queue_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_item_key     (i_item_key),
        .i_item_payload (i_item_payload),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_key      (o_out_key),
        .o_out_payload  (o_out_payload),
        .o_entry_count  (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: check each transfer, then pick the next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(o_status, o_out_key, o_out_payload, o_entry_count);
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Small keys make ties common; the rest spread over the full range and its ends.
    function automatic logic [bmhq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0, 1:    return $urandom_range(15);
            2:       return $urandom();
            default: return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3)
                                              : $urandom_range(3);
        endcase
    endfunction

    // Present one item and hold it until the transfer; valid stays up for the next one.
    task automatic send_item(bmhq_pkg::t_opcode op, logic [bmhq_pkg::KEY_W-1:0] key,
                             logic [bmhq_pkg::PAY_W-1:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_item_key     <= key;
        i_item_payload <= tag;
        do
            @(posedge i_clk);
        while (!o_ready);
        board.note_request(op, key, tag);
    endtask

    task automatic send_random(int unsigned n, int unsigned extract_pct);
        bmhq_pkg::t_opcode op;
        int unsigned       r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < extract_pct)
                op = bmhq_pkg::OP_EXTRACT;
            else begin
                r = $urandom_range(99);
                op = (r < 55) ? bmhq_pkg::OP_INSERT :
                     (r < 80) ? bmhq_pkg::OP_APPEND : bmhq_pkg::OP_BUILD;
            end
            send_item(op, pick_key(), 16'($urandom_range(16'hFFFF)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty heap: underflow, then build with nothing to order
        send_item(bmhq_pkg::OP_EXTRACT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(bmhq_pkg::OP_BUILD, 32'h0, 16'h0);
        send_item(bmhq_pkg::OP_INSERT, 32'd5, 16'h0001);
        send_item(bmhq_pkg::OP_BUILD, 32'h0, 16'h0);
        send_item(bmhq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(bmhq_pkg::OP_INSERT, 32'h0, 16'h0000);
        // equal keys: insert stops at the equal parent, extract takes the left child
        send_item(bmhq_pkg::OP_INSERT, 32'd5, 16'h0002);
        send_item(bmhq_pkg::OP_INSERT, 32'd5, 16'h0003);
        send_item(bmhq_pkg::OP_EXTRACT, 32'h0, 16'h0);
        send_item(bmhq_pkg::OP_EXTRACT, 32'h0, 16'h0);
        send_item(bmhq_pkg::OP_EXTRACT, 32'h0, 16'h0);
        // unordered appends, then heapify
        send_item(bmhq_pkg::OP_APPEND, 32'd9, 16'hAAAA);
        send_item(bmhq_pkg::OP_APPEND, 32'd1, 16'h5555);
        send_item(bmhq_pkg::OP_APPEND, 32'd7, 16'h00FF);
        send_item(bmhq_pkg::OP_APPEND, 32'd1, 16'hFF00);
        send_item(bmhq_pkg::OP_BUILD, 32'hFFFF_FFFF, 16'hFFFF);
        while (board.held_count > 0)
            send_item(bmhq_pkg::OP_EXTRACT, 32'h0, 16'h0);
        send_item(bmhq_pkg::OP_EXTRACT, 32'h0, 16'h0);

        send_random(150, 35);

        send_idle_pct = 59;
        recv_idle_pct = 28;
        // fill to capacity, then hit the full case with both kinds of store
        while (board.held_count < bmhq_pkg::CAPACITY)
            send_item($urandom_range(1) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_APPEND,
                      pick_key(), 16'($urandom_range(16'hFFFF)));
        repeat (3) send_item(bmhq_pkg::OP_INSERT, pick_key(), 16'($urandom_range(16'hFFFF)));
        repeat (3) send_item(bmhq_pkg::OP_APPEND, pick_key(), 16'($urandom_range(16'hFFFF)));
        send_item(bmhq_pkg::OP_BUILD, pick_key(), 16'($urandom_range(16'hFFFF)));
        repeat (40) send_item(bmhq_pkg::OP_EXTRACT, pick_key(),
                              16'($urandom_range(16'hFFFF)));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(120, 60);
        i_valid <= 1'b0;

        while (board.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: files.f
hdl/bmhq_pkg.sv
hdl/bmhq_ram.sv
hdl/binary_min_heap_queue_unit.sv
tb/binary_min_heap_queue_unit_test.sv
